### src/best_edge_addition_search_unit_assert.svh
// Assertion macros shared by the best edge addition search unit.
// Depends on signals named clk and rst_n in the including scope.
`ifndef BEST_EDGE_ADDITION_SEARCH_UNIT_ASSERT_SVH
`define BEST_EDGE_ADDITION_SEARCH_UNIT_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define BEASU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("beasu assertion failed");
// Next-cycle implication, checked outside reset.
`define BEASU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("beasu assertion failed");
`else
`define BEASU_ASSERT_NOW(lbl, ante, cons)
`define BEASU_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### src/beasu_pkg.sv
// Shared constants, state encoding and controller/datapath handshake types.
// No dependencies.
package beasu_pkg;

    localparam int MAX_NODES_DEF  = 32;
    localparam int DIST_WIDTH_DEF = 16;
    localparam int SUM_W          = 26;
    localparam int NODE_CFG_W     = 6;
    localparam int WEIGHT_W       = 16;
    localparam int COST_W         = 16;
    localparam int NODE_FIELD_W   = 5;
    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;

    localparam logic [NODE_CFG_W-1:0] NODE_COUNT_RESET = NODE_CFG_W'(32);
    localparam logic [SUM_W-1:0]      SUM_MAX          = '1;

    // Register index codes, taken from paddr[2].
    localparam logic REG_NODE_COUNT = 1'b0;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } beasu_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW_RD,
        ST_ROW_WAIT,
        ST_PAIR_RD,
        ST_PAIR_EX,
        ST_FINISH
    } beasu_state_t;

    typedef struct packed {
        logic load_wr;
        logic eval_begin;
        logic row_rd;
        logic row_latch;
        logic pair_ex;
        logic out_load;
    } beasu_cmd_t;

    typedef struct packed {
        logic load_last;
        logic matrix_ready;
        logic solving;
        logic row_end;
        logic pass_last;
        logic out_free;
    } beasu_status_t;

endpackage

### src/beasu_in_if.sv
// Input channel: one beat carries a matrix load or a candidate edge.
// Depends on beasu_pkg.
interface beasu_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 cmd;
    logic [beasu_pkg::WEIGHT_W-1:0]       weight;
    logic [beasu_pkg::NODE_FIELD_W-1:0]   edge_source;
    logic [beasu_pkg::NODE_FIELD_W-1:0]   edge_target;
    logic [beasu_pkg::COST_W-1:0]         edge_cost;
    logic                                 last_edge;

    modport source (output valid, cmd, weight, edge_source, edge_target, edge_cost,
                    last_edge, input ready);
    modport sink (input valid, cmd, weight, edge_source, edge_target, edge_cost,
                  last_edge, output ready);
endinterface

### src/beasu_out_if.sv
// Result channel: one beat per evaluated candidate edge.
// Depends on beasu_pkg.
interface beasu_out_if;
    logic                         valid;
    logic                         ready;
    logic [beasu_pkg::SUM_W-1:0]  path_sum;
    logic [beasu_pkg::SUM_W-1:0]  best_sum;
    logic                         set_done;

    modport source (output valid, path_sum, best_sum, set_done, input ready);
    modport sink (input valid, path_sum, best_sum, set_done, output ready);
endinterface

### src/beasu_ctrl.sv
// Sequencer for loads, the all-pairs solve and candidate edge passes.
// Depends on beasu_pkg.
module beasu_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_cmd,
    output logic                     in_ready,
    input  beasu_pkg::beasu_status_t st,
    output beasu_pkg::beasu_cmd_t    cmd
);
    import beasu_pkg::*;

    beasu_state_t state_reg;
    beasu_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (beasu_op_t'(in_cmd) == OP_LOAD)
                    begin
                        cmd.load_wr = 1'b1;
                        if (st.load_last)
                        begin
                            state_next = ST_ROW_RD;
                        end
                    end
                    else if (st.matrix_ready)
                    begin
                        cmd.eval_begin = 1'b1;
                        state_next     = ST_ROW_RD;
                    end
                end
            end
            ST_ROW_RD:
            begin
                cmd.row_rd = 1'b1;
                state_next = ST_ROW_WAIT;
            end
            ST_ROW_WAIT:
            begin
                cmd.row_latch = 1'b1;
                state_next    = ST_PAIR_RD;
            end
            ST_PAIR_RD:
            begin
                state_next = ST_PAIR_EX;
            end
            ST_PAIR_EX:
            begin
                cmd.pair_ex = 1'b1;
                if (st.pass_last)
                begin
                    state_next = st.solving ? ST_IDLE : ST_FINISH;
                end
                else if (st.row_end)
                begin
                    state_next = ST_ROW_RD;
                end
                else
                begin
                    state_next = ST_PAIR_RD;
                end
            end
            ST_FINISH:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### src/beasu_dp.sv
// Datapath: distance memory, pass counters, relaxation, sum and result register.
// Depends on beasu_pkg and the assertion macro header.
`include "best_edge_addition_search_unit_assert.svh"
module beasu_dp #(
    parameter int MAX_NODES  = beasu_pkg::MAX_NODES_DEF,
    parameter int DIST_WIDTH = beasu_pkg::DIST_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  beasu_pkg::beasu_cmd_t               cmd,
    output beasu_pkg::beasu_status_t            st,
    input  logic [beasu_pkg::WEIGHT_W-1:0]      weight,
    input  logic [beasu_pkg::NODE_FIELD_W-1:0]  edge_source,
    input  logic [beasu_pkg::NODE_FIELD_W-1:0]  edge_target,
    input  logic [beasu_pkg::COST_W-1:0]        edge_cost,
    input  logic                                last_edge,
    input  logic                                cfg_wr,
    input  logic [beasu_pkg::NODE_CFG_W-1:0]    cfg_data,
    output logic [beasu_pkg::NODE_CFG_W-1:0]    node_count,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [beasu_pkg::SUM_W-1:0]         path_sum,
    output logic [beasu_pkg::SUM_W-1:0]         best_sum,
    output logic                                set_done
);
    import beasu_pkg::*;

    localparam int IDX_W  = $clog2(MAX_NODES);
    localparam int CNT_W  = $clog2(MAX_NODES + 1);
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int WIDE_W = ((DIST_WIDTH > SUM_W) ? DIST_WIDTH : SUM_W) + 1;
    localparam int EXT_W  = ((DIST_WIDTH > WEIGHT_W) ? DIST_WIDTH : WEIGHT_W) + 1;
    localparam logic [DIST_WIDTH-1:0] INF = '1;

    typedef logic [DIST_WIDTH-1:0] dist_t;

    // Saturating add; the unreachable code absorbs everything.
    function automatic dist_t sat_add(dist_t a, dist_t b);
        logic [DIST_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (a == INF || b == INF || s >= {1'b0, INF})
        begin
            return INF;
        end
        return s[DIST_WIDTH-1:0];
    endfunction

    // Clamp a 16-bit field to the distance range.
    function automatic dist_t clamp_in(logic [WEIGHT_W-1:0] v);
        if (EXT_W'(v) > EXT_W'(INF))
        begin
            return INF;
        end
        return DIST_WIDTH'(v);
    endfunction

    dist_t              mem [DEPTH];
    dist_t              rd_a_reg;
    dist_t              rd_b_reg;
    logic [ADDR_W-1:0]  ra;
    logic [ADDR_W-1:0]  wa;
    dist_t              wd;
    logic               mem_we;

    logic [NODE_CFG_W-1:0] node_count_reg;
    logic [CNT_W-1:0]      nodes_eff;
    logic [CNT_W-1:0]      nodes_m1;
    logic [IDX_W-1:0]      last_idx;

    logic [IDX_W-1:0]  load_row_reg;
    logic [IDX_W-1:0]  load_col_reg;
    logic [IDX_W-1:0]  eff_row;
    logic [IDX_W-1:0]  eff_col;
    logic              matrix_ready_reg;
    logic              solve_reg;
    logic [IDX_W-1:0]  i_reg;
    logic [IDX_W-1:0]  j_reg;
    logic [IDX_W-1:0]  k_reg;
    logic [IDX_W-1:0]  src_reg;
    logic [IDX_W-1:0]  dst_reg;
    logic              edge_ok_reg;
    dist_t             cost_reg;
    logic              last_reg;
    dist_t             row_val_reg;
    logic [SUM_W-1:0]  acc_reg;
    logic [SUM_W-1:0]  running_best_reg;
    logic [SUM_W-1:0]  best_next;
    logic              out_valid_reg;
    logic [SUM_W-1:0]  path_sum_reg;
    logic [SUM_W-1:0]  best_sum_reg;
    logic              set_done_reg;

    logic [IDX_W-1:0]  prow;
    logic [IDX_W-1:0]  pcol;
    dist_t             via;
    dist_t             dmin;
    logic [WIDE_W-1:0] acc_sum;

    // Effective node count, clamped to 2..MAX_NODES.
    always_comb
    begin
        if (node_count_reg < NODE_CFG_W'(2))
        begin
            nodes_eff = CNT_W'(2);
        end
        else if (32'(node_count_reg) > 32'(MAX_NODES))
        begin
            nodes_eff = CNT_W'(MAX_NODES);
        end
        else
        begin
            nodes_eff = CNT_W'(node_count_reg);
        end
        nodes_m1 = nodes_eff - CNT_W'(1);
        last_idx = IDX_W'(nodes_m1);
    end

    // Pivots, load position, relaxation, wide path sum and running minimum.
    always_comb
    begin
        prow    = solve_reg ? k_reg : dst_reg;
        pcol    = solve_reg ? k_reg : src_reg;
        eff_row = matrix_ready_reg ? '0 : load_row_reg;
        eff_col = matrix_ready_reg ? '0 : load_col_reg;
        via     = sat_add(row_val_reg, rd_a_reg);
        dmin    = ((solve_reg || edge_ok_reg) && via < rd_b_reg) ? via : rd_b_reg;
        acc_sum = WIDE_W'(acc_reg) + WIDE_W'(dmin);
        best_next = (acc_reg < running_best_reg) ? acc_reg : running_best_reg;
    end

    // Memory port selection.
    always_comb
    begin
        ra     = cmd.row_rd ? {i_reg, pcol} : {prow, j_reg};
        mem_we = 1'b0;
        wa     = {i_reg, j_reg};
        wd     = via;
        if (cmd.load_wr)
        begin
            mem_we = 1'b1;
            wa     = {eff_row, eff_col};
            wd     = clamp_in(weight);
        end
        else if (cmd.pair_ex && solve_reg && via < rd_b_reg)
        begin
            mem_we = 1'b1;
        end
    end

    // Distance memory with registered reads.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wa] <= wd;
        end
        rd_a_reg <= mem[ra];
        rd_b_reg <= mem[{i_reg, j_reg}];
    end

    // Control registers: load position, pass counters, flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg   <= NODE_COUNT_RESET;
            load_row_reg     <= '0;
            load_col_reg     <= '0;
            matrix_ready_reg <= 1'b0;
            solve_reg        <= 1'b0;
            i_reg            <= '0;
            j_reg            <= '0;
            k_reg            <= '0;
            running_best_reg <= SUM_MAX;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                node_count_reg   <= cfg_data;
                load_row_reg     <= '0;
                load_col_reg     <= '0;
                matrix_ready_reg <= 1'b0;
            end
            if (cmd.load_wr)
            begin
                matrix_ready_reg <= 1'b0;
                if (st.load_last)
                begin
                    load_row_reg <= '0;
                    load_col_reg <= '0;
                    solve_reg    <= 1'b1;
                    i_reg        <= '0;
                    j_reg        <= '0;
                    k_reg        <= '0;
                end
                else if (eff_col == last_idx)
                begin
                    load_col_reg <= '0;
                    load_row_reg <= eff_row + IDX_W'(1);
                end
                else
                begin
                    load_row_reg <= eff_row;
                    load_col_reg <= eff_col + IDX_W'(1);
                end
            end
            if (cmd.eval_begin)
            begin
                solve_reg <= 1'b0;
                i_reg     <= '0;
                j_reg     <= '0;
            end
            if (cmd.pair_ex)
            begin
                if (j_reg == last_idx)
                begin
                    j_reg <= '0;
                    if (i_reg == last_idx)
                    begin
                        i_reg <= '0;
                        if (solve_reg)
                        begin
                            k_reg <= k_reg + IDX_W'(1);
                            if (k_reg == last_idx)
                            begin
                                solve_reg        <= 1'b0;
                                matrix_ready_reg <= 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        i_reg <= i_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    j_reg <= j_reg + IDX_W'(1);
                end
            end
            // Result register and set-wide minimum.
            if (cmd.out_load)
            begin
                out_valid_reg    <= 1'b1;
                running_best_reg <= last_reg ? SUM_MAX : best_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers of the edge pass.
    always_ff @(posedge clk)
    begin
        if (cmd.eval_begin)
        begin
            src_reg     <= IDX_W'(edge_source);
            dst_reg     <= IDX_W'(edge_target);
            edge_ok_reg <= (32'(edge_source) < 32'(nodes_eff))
                        && (32'(edge_target) < 32'(nodes_eff));
            cost_reg    <= clamp_in(edge_cost);
            last_reg    <= last_edge;
            acc_reg     <= '0;
        end
        if (cmd.row_latch)
        begin
            row_val_reg <= sat_add(rd_a_reg, solve_reg ? '0 : cost_reg);
        end
        if (cmd.pair_ex && !solve_reg && dmin != INF)
        begin
            acc_reg <= (acc_sum > WIDE_W'(SUM_MAX)) ? SUM_MAX : acc_sum[SUM_W-1:0];
        end
        if (cmd.out_load)
        begin
            path_sum_reg <= acc_reg;
            best_sum_reg <= best_next;
            set_done_reg <= last_reg;
        end
    end

    // Status back to the sequencer.
    always_comb
    begin
        st.load_last    = (eff_row == last_idx) && (eff_col == last_idx);
        st.matrix_ready = matrix_ready_reg;
        st.solving      = solve_reg;
        st.row_end      = (j_reg == last_idx);
        st.pass_last    = (j_reg == last_idx) && (i_reg == last_idx)
                       && (!solve_reg || k_reg == last_idx);
        st.out_free     = !out_valid_reg || out_ready;
    end

    assign node_count = node_count_reg;
    assign out_valid  = out_valid_reg;
    assign path_sum   = path_sum_reg;
    assign best_sum   = best_sum_reg;
    assign set_done   = set_done_reg;

    // An edge pass never rewrites the solved matrix.
    `BEASU_ASSERT_NOW(a_eval_no_write, cmd.pair_ex && !solve_reg, !mem_we)
    // A finished pass always presents a result beat.
    `BEASU_ASSERT_NEXT(a_out_loaded, cmd.out_load, out_valid_reg)
    // The reported minimum never exceeds this beat's sum.
    `BEASU_ASSERT_NEXT(a_best_le_sum, cmd.out_load, best_sum_reg <= path_sum_reg)
    // The set minimum restarts after the closing edge.
    `BEASU_ASSERT_NEXT(a_best_restart, cmd.out_load && last_reg, running_best_reg == SUM_MAX)

endmodule

### src/best_edge_addition_search_unit.sv
// Top level: APB register port, sequencer and datapath.
// Depends on beasu_pkg, beasu_in_if, beasu_out_if, beasu_ctrl and beasu_dp.
//
// Load beats (cmd 0) fill the distance matrix in row-major order, one per cycle;
// the beat that completes it starts an all-pairs solve, during which no beat is
// taken. An evaluate beat (cmd 1) then walks all n*n pairs row by row.
// Evaluate beats before a complete load are dropped without a result. The
// result register lets the next beat enter while a result waits.
module best_edge_addition_search_unit #(
    parameter int MAX_NODES  = beasu_pkg::MAX_NODES_DEF,
    parameter int DIST_WIDTH = beasu_pkg::DIST_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    beasu_in_if.sink                         in_ch,
    beasu_out_if.source                      out_ch,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [beasu_pkg::PADDR_W-1:0]    paddr,
    input  logic [beasu_pkg::PDATA_W-1:0]    pwdata,
    output logic [beasu_pkg::PDATA_W-1:0]    prdata,
    output logic                             pready
);
    import beasu_pkg::*;

    beasu_cmd_t             cmd;
    beasu_status_t          st;
    logic                   cfg_wr;
    logic [NODE_CFG_W-1:0]  node_count;

    // Register decode.
    always_comb
    begin
        pready = 1'b1;
        cfg_wr = psel && penable && pwrite && (paddr[2] == REG_NODE_COUNT);
        prdata = '0;
        if (paddr[2] == REG_NODE_COUNT)
        begin
            prdata = PDATA_W'(node_count);
        end
    end

    beasu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_cmd   (in_ch.cmd),
        .in_ready (in_ch.ready),
        .st       (st),
        .cmd      (cmd)
    );

    beasu_dp #(
        .MAX_NODES  (MAX_NODES),
        .DIST_WIDTH (DIST_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .weight      (in_ch.weight),
        .edge_source (in_ch.edge_source),
        .edge_target (in_ch.edge_target),
        .edge_cost   (in_ch.edge_cost),
        .last_edge   (in_ch.last_edge),
        .cfg_wr      (cfg_wr),
        .cfg_data    (pwdata[NODE_CFG_W-1:0]),
        .node_count  (node_count),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .path_sum    (out_ch.path_sum),
        .best_sum    (out_ch.best_sum),
        .set_done    (out_ch.set_done)
    );

endmodule
